[rtl/fbcc_pkg.sv]
package fbcc_pkg;

    // Field widths of the request, response and configuration channels
    localparam int KEY_HIGH_W = 64;
    localparam int KEY_MID_W  = 64;
    localparam int KEY_LOW_W  = 32;
    localparam int LEN_W      = 17;
    localparam int COUNT_W    = 9;
    localparam int BUDGET_W   = 25;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 25'd16777216;
    localparam longint BUDGET_MAX = (longint'(1) << BUDGET_W) - 1;
    localparam int LEN_MAX = (1 << LEN_W) - 1;

    // Defaults for the top-level parameters
    localparam int DEF_RING_ENTRIES    = 256;
    localparam int DEF_MAX_CHUNK_BYTES = 65536;
    localparam int DEF_ENTRY_OVERHEAD  = 64;

    // Request codes
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture a new request, clear per-request results
        logic scan_issue;  // read the next held slot of the search
        logic hit_take;    // record the matching slot's length
        logic ev_init;     // arm the eviction target
        logic drop;        // evict the oldest entry
        logic append;      // write the new entry at the tail
        logic out_load;    // move results into the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic match;       // registered read row equals the requested name
        logic scan_end;    // every held slot has been read
        logic found;       // name found earlier in this request
        logic insert_ok;   // insert with a length within the limit
        logic ev_more;     // eviction target not reached and ring not empty
        logic ring_full;   // every slot is held
    } status_t;

endpackage

[rtl/fbcc_if.sv]
interface fbcc_req_if import fbcc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [KEY_HIGH_W-1:0] key_high;
    logic [KEY_MID_W-1:0]  key_mid;
    logic [KEY_LOW_W-1:0]  key_low;
    logic [LEN_W-1:0]      chunk_len;

    modport source (output valid, req_type, key_high, key_mid, key_low, chunk_len,
                    input ready);
    modport sink (input valid, req_type, key_high, key_mid, key_low, chunk_len,
                  output ready);
endinterface

interface fbcc_rsp_if import fbcc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                found;
    logic [LEN_W-1:0]    found_length;
    logic                inserted;
    logic [COUNT_W-1:0]  evicted_count;
    logic [BUDGET_W-1:0] used_bytes;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, found, found_length, inserted, evicted_count,
                    used_bytes, entry_count, input ready);
    modport sink (input valid, found, found_length, inserted, evicted_count,
                  used_bytes, entry_count, output ready);
endinterface

interface fbcc_cfg_if import fbcc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BUDGET_W-1:0] max_cache_size;

    modport source (output valid, max_cache_size, input ready);
    modport sink (input valid, max_cache_size, output ready);
endinterface

[rtl/fbcc_ctrl.sv]
module fbcc_ctrl import fbcc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_EVICT  = 3'd3;
    localparam logic [2:0] S_APPEND = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (status.match)
                begin
                    cmd.hit_take = 1'b1;
                    state_next   = S_DECIDE;
                end
                else if (status.scan_end)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                end
            end
            S_DECIDE:
            begin
                if (status.insert_ok && !status.found)
                begin
                    cmd.ev_init = 1'b1;
                    state_next  = S_EVICT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EVICT:
            begin
                priority if (status.ev_more)
                begin
                    cmd.drop = 1'b1;
                end
                else if (status.ring_full)
                begin
                    cmd.drop   = 1'b1;
                    state_next = S_APPEND;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("request captured outside idle");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.out_load)
        else $error("result overwritten while waiting");

    a_drop_then_more: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.drop && state_reg == S_EVICT && status.ring_full && !status.ev_more)
        |=> state_reg == S_APPEND)
        else $error("full-ring eviction not followed by append");

endmodule

[rtl/fbcc_dp.sv]
module fbcc_dp import fbcc_pkg::*; #(
    parameter int RING_ENTRIES    = DEF_RING_ENTRIES,
    parameter int MAX_CHUNK_BYTES = DEF_MAX_CHUNK_BYTES,
    parameter int ENTRY_OVERHEAD  = DEF_ENTRY_OVERHEAD
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  req_type,
    input  logic [KEY_HIGH_W-1:0] key_high,
    input  logic [KEY_MID_W-1:0]  key_mid,
    input  logic [KEY_LOW_W-1:0]  key_low,
    input  logic [LEN_W-1:0]      chunk_len,
    input  logic                  cfg_we,
    input  logic [BUDGET_W-1:0]   cfg_data,
    output logic                  found,
    output logic [LEN_W-1:0]      found_length,
    output logic                  inserted,
    output logic [COUNT_W-1:0]    evicted_count,
    output logic [BUDGET_W-1:0]   used_bytes,
    output logic [COUNT_W-1:0]    entry_count
);

    localparam int SLOT_W   = $clog2(RING_ENTRIES);
    localparam int CNT_W    = $clog2(RING_ENTRIES + 1);
    localparam int LEN_CAP  = (MAX_CHUNK_BYTES < LEN_MAX) ? MAX_CHUNK_BYTES : LEN_MAX;
    localparam int COST_MAX = ENTRY_OVERHEAD + LEN_CAP;
    localparam int COST_W   = $clog2(COST_MAX + 1);
    localparam int REM_W    = COST_W + 1;
    localparam longint FILL_MAX = longint'(RING_ENTRIES) * longint'(COST_MAX);
    localparam longint USE_MAX  = (FILL_MAX > BUDGET_MAX) ? FILL_MAX : BUDGET_MAX;
    localparam int USE_W    = $clog2(USE_MAX + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_ENTRIES - 1);

    typedef struct packed {
        logic [KEY_HIGH_W-1:0] key_high;
        logic [KEY_MID_W-1:0]  key_mid;
        logic [KEY_LOW_W-1:0]  key_low;
        logic [LEN_W-1:0]      len;
    } entry_t;

    entry_t entry_mem [RING_ENTRIES];
    entry_t rd_row_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] tail_slot;

    // Captured request
    logic                  req_type_reg;
    logic [KEY_HIGH_W-1:0] key_high_reg;
    logic [KEY_MID_W-1:0]  key_mid_reg;
    logic [KEY_LOW_W-1:0]  key_low_reg;
    logic [LEN_W-1:0]      blen_reg;

    // Ring state
    logic [SLOT_W-1:0]   oldest_reg, oldest_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [USE_W-1:0]    usage_reg, usage_next;
    logic [BUDGET_W-1:0] budget_reg;

    // Per-request working state
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [SLOT_W-1:0] scan_slot_reg;
    logic              pend_reg;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              found_reg;
    logic [LEN_W-1:0]  flen_reg;
    logic              inserted_reg;
    logic [CNT_W-1:0]  evicted_reg;

    // Output register
    logic                found_out_reg;
    logic [LEN_W-1:0]    flen_out_reg;
    logic                inserted_out_reg;
    logic [COUNT_W-1:0]  evicted_out_reg;
    logic [BUDGET_W-1:0] used_out_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    logic [COST_W-1:0]  new_cost;
    logic [COST_W-1:0]  drop_cost;
    logic [USE_W:0]     usage_sum;
    logic [SLOT_W-1:0]  oldest_inc;
    logic [SLOT_W-1:0]  scan_slot_inc;
    logic [CNT_W:0]     tail_sum;
    logic               key_eq;

    assign new_cost  = COST_W'(ENTRY_OVERHEAD) + COST_W'(blen_reg);
    assign drop_cost = COST_W'(ENTRY_OVERHEAD) + COST_W'(rd_row_reg.len);
    assign usage_sum = (USE_W+1)'(usage_reg) + (USE_W+1)'(new_cost);

    assign oldest_inc    = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + 1'b1;
    assign scan_slot_inc = (scan_slot_reg == LAST_SLOT) ? '0 : scan_slot_reg + 1'b1;

    // Tail slot: oldest plus count, wrapped once
    assign tail_sum  = (CNT_W+1)'(oldest_reg) + (CNT_W+1)'(held_reg);
    assign tail_slot = (tail_sum >= (CNT_W+1)'(RING_ENTRIES))
                     ? SLOT_W'(tail_sum - (CNT_W+1)'(RING_ENTRIES))
                     : SLOT_W'(tail_sum);

    always_comb
    begin
        priority if (cmd.scan_issue)
            rd_addr = scan_slot_reg;
        else if (cmd.drop)
            rd_addr = oldest_inc;
        else
            rd_addr = oldest_reg;
    end

    assign key_eq = (rd_row_reg.key_high == key_high_reg) &&
                    (rd_row_reg.key_mid == key_mid_reg) &&
                    (rd_row_reg.key_low == key_low_reg);

    assign status.match     = pend_reg && key_eq;
    assign status.scan_end  = (scan_idx_reg == held_reg);
    assign status.found     = found_reg;
    assign status.insert_ok = (req_type_reg == REQ_INSERT) &&
                              (32'(blen_reg) <= MAX_CHUNK_BYTES);
    assign status.ev_more   = (rem_reg != '0) && (held_reg != '0);
    assign status.ring_full = (held_reg == CNT_W'(RING_ENTRIES));

    always_comb
    begin
        if (32'(rd_row_reg.len) >= 32'(rem_reg))
            rem_next = '0;
        else
            rem_next = rem_reg - REM_W'(rd_row_reg.len);
    end

    always_comb
    begin
        oldest_next = oldest_reg;
        held_next   = held_reg;
        usage_next  = usage_reg;
        if (cmd.drop)
        begin
            oldest_next = oldest_inc;
            held_next   = held_reg - 1'b1;
            usage_next  = (usage_reg >= USE_W'(drop_cost)) ? usage_reg - USE_W'(drop_cost)
                                                           : '0;
        end
        if (cmd.append)
        begin
            held_next  = held_reg + 1'b1;
            usage_next = USE_W'(usage_sum);
        end
    end

    // Memory: one write port at the tail, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.append)
            entry_mem[tail_slot] <= '{key_high_reg, key_mid_reg, key_low_reg, blen_reg};
        rd_row_reg <= entry_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            held_reg   <= '0;
            usage_reg  <= '0;
            budget_reg <= BUDGET_RESET;
            pend_reg   <= 1'b0;
        end
        else
        begin
            oldest_reg <= oldest_next;
            held_reg   <= held_next;
            usage_reg  <= usage_next;
            pend_reg   <= cmd.scan_issue;
            if (cfg_we)
                budget_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg  <= req_type;
            key_high_reg  <= key_high;
            key_mid_reg   <= key_mid;
            key_low_reg   <= key_low;
            blen_reg      <= chunk_len;
            scan_idx_reg  <= '0;
            scan_slot_reg <= oldest_reg;
            found_reg     <= 1'b0;
            flen_reg      <= '0;
            inserted_reg  <= 1'b0;
            evicted_reg   <= '0;
            rem_reg       <= '0;
        end
        if (cmd.scan_issue)
        begin
            scan_idx_reg  <= scan_idx_reg + 1'b1;
            scan_slot_reg <= scan_slot_inc;
        end
        if (cmd.hit_take)
        begin
            found_reg <= 1'b1;
            flen_reg  <= rd_row_reg.len;
        end
        if (cmd.ev_init)
            rem_reg <= (usage_sum > (USE_W+1)'(budget_reg)) ? {new_cost, 1'b0} : '0;
        if (cmd.drop)
        begin
            rem_reg     <= rem_next;
            evicted_reg <= evicted_reg + 1'b1;
        end
        if (cmd.append)
            inserted_reg <= 1'b1;
        if (cmd.out_load)
        begin
            found_out_reg    <= found_reg;
            flen_out_reg     <= flen_reg;
            inserted_out_reg <= inserted_reg;
            evicted_out_reg  <= COUNT_W'(evicted_reg);
            used_out_reg     <= BUDGET_W'(usage_reg);
            count_out_reg    <= COUNT_W'(held_reg);
        end
    end

    assign found         = found_out_reg;
    assign found_length  = flen_out_reg;
    assign inserted      = inserted_out_reg;
    assign evicted_count = evicted_out_reg;
    assign used_bytes    = used_out_reg;
    assign entry_count   = count_out_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(RING_ENTRIES))
        else $error("entry count beyond ring size");

    a_empty_no_usage: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg == '0) |-> (usage_reg == '0))
        else $error("bytes accounted with an empty ring");

    a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !status.ring_full)
        else $error("append into a full ring");

    a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.drop && !cmd.append) |=> held_reg == $past(held_reg) - 1'b1)
        else $error("eviction did not lower the entry count");

endmodule

[rtl/fifo_byte_budget_chunk_cache.sv]
// FIFO chunk-name cache with a byte budget. Each request (lookup or insert of a
// 160-bit name) yields exactly one response. The ring of up to RING_ENTRIES names
// lives in a memory with one write port and a registered read port, so every step
// of work is one slot per cycle: the name search reads held slots oldest first and
// stops at the first hit, and an insert that overflows the budget evicts oldest
// entries one per cycle until their stored lengths add up to twice the new entry's
// cost in bytes or the ring is empty (a full ring also loses its oldest entry). A
// request passes through accept, search, decide, eviction and append on a new
// insert, and response posting, in that order. Requests are handled one at a time;
// a new request is accepted as soon as the previous one has its response posted,
// even if that response is still waiting to be taken. The byte budget register
// (max_cache_size) resets to 16 MiB, is written over the cfg channel, which is
// always ready, and must only be written while no request is in flight. Lowering
// it below current usage takes effect at the next new insert. Entry memory is not
// cleared at reset; only rows read from held slots are ever used.
module fifo_byte_budget_chunk_cache import fbcc_pkg::*; #(
    parameter int RING_ENTRIES    = DEF_RING_ENTRIES,
    parameter int MAX_CHUNK_BYTES = DEF_MAX_CHUNK_BYTES,
    parameter int ENTRY_OVERHEAD  = DEF_ENTRY_OVERHEAD
) (
    input logic        clk,
    input logic        rst_n,
    fbcc_req_if.sink   req,
    fbcc_rsp_if.source rsp,
    fbcc_cfg_if.sink   cfg
);

    cmd_t    cmd;
    status_t status;

    // Budget writes always complete in one transfer
    assign cfg.ready = 1'b1;

    // Controller: sequences search, eviction, append and response posting
    fbcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: entry memory, ring pointers, byte accounting, response register
    fbcc_dp #(
        .RING_ENTRIES    (RING_ENTRIES),
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES),
        .ENTRY_OVERHEAD  (ENTRY_OVERHEAD)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .req_type      (req.req_type),
        .key_high      (req.key_high),
        .key_mid       (req.key_mid),
        .key_low       (req.key_low),
        .chunk_len     (req.chunk_len),
        .cfg_we        (cfg.valid),
        .cfg_data      (cfg.max_cache_size),
        .found         (rsp.found),
        .found_length  (rsp.found_length),
        .inserted      (rsp.inserted),
        .evicted_count (rsp.evicted_count),
        .used_bytes    (rsp.used_bytes),
        .entry_count   (rsp.entry_count)
    );

endmodule

[tb/cache_check_pkg.sv]
package cache_check_pkg;
    import fbcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SLOTS     = DEF_RING_ENTRIES;
    localparam int MAX_CHUNK      = DEF_MAX_CHUNK_BYTES;
    localparam int SLOT_OVERHEAD  = DEF_ENTRY_OVERHEAD;

    typedef struct packed {
        logic                found;
        logic [LEN_W-1:0]    found_length;
        logic                inserted;
        logic [COUNT_W-1:0]  evicted_count;
        logic [BUDGET_W-1:0] used_bytes;
        logic [COUNT_W-1:0]  entry_count;
    } cache_reply_t;

    // Mirror of the cache: ring contents, usage and budget, plus the replies owed.
    class chunk_cache_mirror;
        logic [KEY_HIGH_W-1:0] upper_names[RING_SLOTS];
        logic [KEY_MID_W-1:0]  middle_names[RING_SLOTS];
        logic [KEY_LOW_W-1:0]  lower_names[RING_SLOTS];
        logic [LEN_W-1:0]      stored_length[RING_SLOTS];
        int unsigned           head_slot;
        int unsigned           held;
        longint unsigned       bytes_used;
        longint unsigned       budget;
        cache_reply_t          replies_due[$];
        int unsigned           mismatches;

        function new();
            head_slot  = 0;
            held       = 0;
            bytes_used = 0;
            budget     = 64'(BUDGET_RESET);
            mismatches = 0;
        endfunction

        function void set_budget(logic [BUDGET_W-1:0] value);
            budget = 64'(value);
        endfunction

        function int unsigned replies_pending();
            return replies_due.size();
        endfunction

        // Drop the oldest entry, refund its full cost, return its length.
        function int unsigned evict_oldest();
            int unsigned len;
            longint unsigned cost;
            len = 32'(stored_length[head_slot]);
            cost = 64'(SLOT_OVERHEAD) + 64'(len);
            bytes_used = (bytes_used >= cost) ? bytes_used - cost : 0;
            head_slot = (head_slot + 1) % RING_SLOTS;
            held--;
            return len;
        endfunction

        function void take_request(logic kind, logic [KEY_HIGH_W-1:0] kh,
                                   logic [KEY_MID_W-1:0] km, logic [KEY_LOW_W-1:0] kl,
                                   logic [LEN_W-1:0] len);
            cache_reply_t r;
            int unsigned slot;
            int unsigned evicted;
            longint unsigned cost;
            longint target;
            r = '0;
            evicted = 0;
            for (int unsigned i = 0; i < held; i++) begin
                slot = (head_slot + i) % RING_SLOTS;
                if (upper_names[slot] == kh && middle_names[slot] == km &&
                    lower_names[slot] == kl) begin
                    r.found = 1'b1;
                    r.found_length = stored_length[slot];
                    break;
                end
            end
            if (kind == REQ_INSERT && !r.found && len <= MAX_CHUNK) begin
                cost = 64'(SLOT_OVERHEAD) + 64'(len);
                if (bytes_used + cost > budget) begin
                    target = longint'(cost * 2);
                    while (target > 0 && held > 0) begin
                        target -= longint'(evict_oldest());
                        evicted++;
                    end
                end
                if (held >= RING_SLOTS) begin
                    void'(evict_oldest());
                    evicted++;
                end
                slot = (head_slot + held) % RING_SLOTS;
                upper_names[slot]   = kh;
                middle_names[slot]  = km;
                lower_names[slot]   = kl;
                stored_length[slot] = len;
                held++;
                bytes_used += cost;
                r.inserted = 1'b1;
            end
            r.evicted_count = evicted[COUNT_W-1:0];
            r.used_bytes    = bytes_used[BUDGET_W-1:0];
            r.entry_count   = held[COUNT_W-1:0];
            replies_due.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t ns  %s: expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_reply(cache_reply_t got);
            cache_reply_t want;
            if (replies_due.size() == 0) begin
                mismatches++;
                $display("%0t ns  response transfer with no request outstanding", $time);
                return;
            end
            want = replies_due.pop_front();
            compare_field("found", 32'(want.found), 32'(got.found));
            compare_field("found_length", 32'(want.found_length), 32'(got.found_length));
            compare_field("inserted", 32'(want.inserted), 32'(got.inserted));
            compare_field("evicted_count", 32'(want.evicted_count), 32'(got.evicted_count));
            compare_field("used_bytes", 32'(want.used_bytes), 32'(got.used_bytes));
            compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        endfunction
    endclass

endpackage

[tb/tb.sv]
module tb;
    import fbcc_pkg::*;
    import cache_check_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Generous ceiling on the length of the run.
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam logic [BUDGET_W-1:0] BUDGET_TOP = 25'd16793600;
    localparam int unsigned NAME_POOL_DEPTH = 320;

    // How block lengths are spread within a phase.
    typedef enum int {SIZES_SHORT, SIZES_MIXED, SIZES_NEAR_MAX} size_mix_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fbcc_req_if req_ch ();
    fbcc_rsp_if rsp_ch ();
    fbcc_cfg_if cfg_ch ();

    fifo_byte_budget_chunk_cache dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    chunk_cache_mirror model;
    logic [159:0]      name_pool[$];   // recently offered names, reused to hit the cache
    bit                no_idle;        // when set, both sides run back to back
    int unsigned       rsp_hold_cycles; // one-shot long stall requested of the receiver
    int unsigned       cycle_count = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one request after a random gap, hold it until the transfer, then log it.
    // Valid is only lowered when a gap follows, so back-to-back items keep it high.
    task automatic send_request(input logic kind, input logic [159:0] name,
                                input logic [LEN_W-1:0] len);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.key_high     <= name[159:96];
        req_ch.key_mid      <= name[95:32];
        req_ch.key_low      <= name[31:0];
        req_ch.chunk_len    <= len;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        model.take_request(kind, name[159:96], name[95:32], name[31:0], len);
    endtask

    // Drop valid and hold until every owed response has been checked.
    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        while (model.replies_pending() != 0 && cycle_count < CYCLE_LIMIT)
            @(posedge clk);
    endtask

    // Write the budget register only while the block is idle.
    task automatic write_budget(input logic [BUDGET_W-1:0] value);
        wait_until_drained();
        cfg_ch.valid          <= 1'b1;
        cfg_ch.max_cache_size <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        model.set_budget(value);
    endtask

    // Pick a name: a recent one (likely a hit), a one-bit neighbor of a recent one
    // (a near miss that must not match), or a fresh random one.
    function automatic logic [159:0] pick_name(int unsigned reuse_pct);
        logic [159:0] nm;
        int unsigned roll;
        int unsigned flip;
        roll = $urandom_range(0, 99);
        if (name_pool.size() > 0 && roll < reuse_pct)
            nm = name_pool[$urandom_range(0, name_pool.size() - 1)];
        else if (name_pool.size() > 0 && roll < reuse_pct + 10)
        begin
            nm = name_pool[$urandom_range(0, name_pool.size() - 1)];
            flip = $urandom_range(0, 159);
            nm[flip] = ~nm[flip];
        end
        else
            nm = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return nm;
    endfunction

    // Oversized, zero and maximum lengths show up in every mix.
    function automatic logic [LEN_W-1:0] pick_length(size_mix_e mix);
        int unsigned roll;
        int unsigned len;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            len = $urandom_range(MAX_CHUNK + 1, LEN_MAX);
        else if (roll < 8)
            len = MAX_CHUNK;
        else if (roll < 10)
            len = 0;
        else
        begin
            case (mix)
                SIZES_SHORT: len = $urandom_range(0, 300);
                SIZES_MIXED: len = $urandom_range(0, MAX_CHUNK);
                default:     len = $urandom_range(60000, MAX_CHUNK);
            endcase
        end
        return len[LEN_W-1:0];
    endfunction

    // One budget setting, then a stream of random lookups and inserts. With pressure
    // set, stall the receiver for a long stretch a third of the way in, and pause the
    // sender until everything is back at two thirds.
    task automatic run_phase(input logic [BUDGET_W-1:0] budget, input int unsigned count,
                             input size_mix_e mix, input int unsigned insert_pct,
                             input int unsigned reuse_pct, input bit pressure);
        logic [159:0] nm;
        logic kind;
        write_budget(budget);
        for (int unsigned n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                no_idle = !no_idle;
            if (pressure && n == count / 3)
                rsp_hold_cycles = 400;
            if (pressure && n == 2 * count / 3)
                wait_until_drained();
            kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_LOOKUP;
            nm = pick_name(reuse_pct);
            send_request(kind, nm, pick_length(mix));
            name_pool.push_back(nm);
            if (name_pool.size() > NAME_POOL_DEPTH)
                void'(name_pool.pop_front());
        end
    endtask

    // Receiver: take each response after a random stall and check it.
    initial
    begin : response_side
        cache_reply_t got;
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                stall = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            got.found         = rsp_ch.found;
            got.found_length  = rsp_ch.found_length;
            got.inserted      = rsp_ch.inserted;
            got.evicted_count = rsp_ch.evicted_count;
            got.used_bytes    = rsp_ch.used_bytes;
            got.entry_count   = rsp_ch.entry_count;
            model.check_reply(got);
        end
    end

    initial
    begin : stimulus
        logic [159:0] all_ones;
        logic [159:0] stripes;
        model = new();
        no_idle = 1'b0;
        rsp_hold_cycles = 0;
        all_ones = '1;
        stripes = {5{32'hAAAA_AAAA}};

        // Hold every input at a known value through reset.
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= REQ_LOOKUP;
        req_ch.key_high       <= '0;
        req_ch.key_mid        <= '0;
        req_ch.key_low        <= '0;
        req_ch.chunk_len      <= '0;
        rsp_ch.ready          <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.max_cache_size <= BUDGET_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the reset budget.
        // Lookup on an empty ring; the length field is ignored.
        send_request(REQ_LOOKUP, all_ones, LEN_MAX[LEN_W-1:0]);
        // Extreme names and lengths.
        send_request(REQ_INSERT, '0, '0);
        send_request(REQ_INSERT, all_ones, LEN_W'(MAX_CHUNK));
        send_request(REQ_LOOKUP, all_ones, '0);
        send_request(REQ_LOOKUP, '0, '1);
        // Duplicate insert keeps the stored length and changes nothing.
        send_request(REQ_INSERT, all_ones, 17'd5);
        // Oversized inserts are ignored and leave no trace.
        send_request(REQ_INSERT, stripes, LEN_MAX[LEN_W-1:0]);
        send_request(REQ_INSERT, stripes, LEN_W'(MAX_CHUNK + 1));
        send_request(REQ_LOOKUP, stripes, '0);
        // Names that differ from a held one in a single field must not match.
        send_request(REQ_INSERT, all_ones ^ 160'd1, 17'd1);
        send_request(REQ_INSERT, all_ones ^ (160'd1 << 159), 17'd2);
        send_request(REQ_INSERT, all_ones ^ (160'd1 << 49), 17'd3);
        send_request(REQ_LOOKUP, all_ones ^ (160'd1 << 49), '0);
        send_request(REQ_LOOKUP, all_ones ^ (160'd1 << 100), '0);
        send_request(REQ_INSERT, stripes, 17'd65535);
        send_request(REQ_INSERT, ~stripes, LEN_W'(MAX_CHUNK));
        send_request(REQ_LOOKUP, ~stripes, '0);

        // Fill the ring with short entries so that a full ring evicts its oldest;
        // exercise the long receiver stall and a full sender pause here.
        run_phase(BUDGET_RESET, 500, SIZES_SHORT, 90, 25, 1'b1);
        // Budget far below usage: the next new insert evicts a run of old entries.
        run_phase(25'd5000, 150, SIZES_SHORT, 60, 45, 1'b0);
        // Zero budget: every new insert triggers eviction and still lands.
        run_phase('0, 80, SIZES_MIXED, 60, 45, 1'b0);
        // A budget just above the reset value with near-maximum chunks.
        run_phase(BUDGET_TOP, 250, SIZES_NEAR_MAX, 90, 25, 1'b0);
        // A random mid-sized budget with mixed lengths.
        run_phase(25'($urandom_range(20000, 1000000)), 150, SIZES_MIXED, 70, 40, 1'b0);

        // Let everything come back, then idle on to catch stray transfers.
        wait_until_drained();
        repeat (40) @(posedge clk);
        if (model.mismatches == 0 && model.replies_pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
